[rtl/quantum_state_vector_sampler_defines.svh]
// Assertion macros shared by the checker of the state vector sampler.
// Depends on nothing; the including module must provide clk and rst.
`ifndef QUANTUM_STATE_VECTOR_SAMPLER_DEFINES_SVH
`define QUANTUM_STATE_VECTOR_SAMPLER_DEFINES_SVH

// Implication in the same cycle, ignored while reset is high.
`define QSVS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qsvs assertion failed");

// Implication into the next cycle, ignored while reset is high.
`define QSVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qsvs assertion failed");

// Implication into the next cycle, checked during reset as well.
`define QSVS_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qsvs assertion failed");

`endif

[rtl/qsvs_pkg.sv]
// Types, codes and helpers of the state vector sampler.
// Used by the store, the iterative unit and the top level.
`timescale 1ns / 1ps
package qsvs_pkg;
  localparam int AMP_W = 18;
  localparam int ENTRY_W = 2 * AMP_W;
  localparam int SQ_W = 64;
  localparam int ROOT_W = 32;
  localparam int DEN_W = ROOT_W + 1;
  localparam int NUM_W = 42;
  localparam int REM_W = 36;
  localparam int OUT_IDX_W = 10;

  typedef logic signed [AMP_W-1:0] amp_t;
  typedef logic [2:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_CLEAR = 3'd0;
  localparam cmd_t CMD_WRITE = 3'd1;
  localparam cmd_t CMD_NORM = 3'd2;
  localparam cmd_t CMD_SAMPLE = 3'd3;
  localparam cmd_t CMD_COLLAPSE = 3'd4;

  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_ZERO_NORM = 2'd1;
  localparam status_t ST_NO_OUTCOME = 2'd2;

  localparam amp_t AMP_ONE = 18'sd65536;
  localparam amp_t AMP_MAX = 18'sd131071;
  localparam amp_t AMP_MIN = -18'sd131072;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } unit_ctl_t;

  function automatic amp_t sat_part(input logic neg, input logic [NUM_W-1:0] q);
    amp_t v;
    v = '0;
    if (neg) begin
      if (q > NUM_W'(131072)) v = AMP_MIN;
      else v = -amp_t'(q[AMP_W-1:0]);
    end else begin
      if (q > NUM_W'(131071)) v = AMP_MAX;
      else v = amp_t'(q[AMP_W-1:0]);
    end
    return v;
  endfunction
endpackage

[rtl/qsvs_store.sv]
// Amplitude memory: one write port, one read port with registered data.
// Depends on qsvs_pkg for the entry width.
`timescale 1ns / 1ps
module qsvs_store #(
  parameter int AW = 10
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [qsvs_pkg::ENTRY_W-1:0]   wdata,
  input  logic [AW-1:0]                  raddr,
  output logic [qsvs_pkg::ENTRY_W-1:0]   rdata
);
  import qsvs_pkg::*;

  logic [ENTRY_W-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/qsvs_unit.sv]
// Shared shift-and-subtract unit: integer square root or restoring division.
// Depends on qsvs_pkg for widths and the control struct.
`timescale 1ns / 1ps
module qsvs_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  qsvs_pkg::unit_ctl_t           ctl,
  input  logic [qsvs_pkg::SQ_W-1:0]     sq_in,
  input  logic [qsvs_pkg::NUM_W-1:0]    num,
  input  logic [qsvs_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [qsvs_pkg::NUM_W-1:0]    res
);
  import qsvs_pkg::*;

  logic              busy;
  logic              mode_sqrt;
  logic [5:0]        steps;
  logic [SQ_W-1:0]   opnd;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  always_comb begin
    if (mode_sqrt) begin
      rem_sh = {rem[REM_W-3:0], opnd[SQ_W-1 -: 2]};
      trial = {res[REM_W-3:0], 2'b01};
    end else begin
      rem_sh = {rem[REM_W-2:0], opnd[SQ_W-1]};
      trial = REM_W'(den);
    end
    fits = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        mode_sqrt <= ctl.is_sqrt;
        steps <= ctl.is_sqrt ? 6'(ROOT_W) : 6'(NUM_W);
        opnd <= ctl.is_sqrt ? sq_in : {num, (SQ_W - NUM_W)'(0)};
        rem <= '0;
        res <= '0;
      end else if (busy) begin
        rem <= fits ? rem_sh - trial : rem_sh;
        res <= {res[NUM_W-2:0], fits};
        opnd <= mode_sqrt ? {opnd[SQ_W-3:0], 2'b00} : {opnd[SQ_W-2:0], 1'b0};
        steps <= steps - 6'd1;
        if (steps == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/quantum_state_vector_sampler.sv]
// A write or an unknown command goes straight to the result; a clear writes every entry.
// A sample reads entries until the running sum passes the draw; a collapse then rewrites
// every entry. Normalize sums all magnitudes, takes the root, and divides both parts of
// every entry in the shared shift-subtract unit, which works one bit a cycle.
// One item at a time; a finished result waits in the output register.
// Reset runs a pass over all 2^QUBITS entries that loads basis state zero, with in_ready low.
`timescale 1ns / 1ps
module quantum_state_vector_sampler #(
  parameter int QUBITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  qsvs_pkg::cmd_t                       cmd,
  input  logic [9:0]                           amp_index,
  input  qsvs_pkg::amp_t                       amp_real,
  input  qsvs_pkg::amp_t                       amp_imag,
  input  logic [15:0]                          random_fraction,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [qsvs_pkg::OUT_IDX_W-1:0]       outcome_index,
  output qsvs_pkg::status_t                    status
);
  import qsvs_pkg::*;

  localparam int AW = QUBITS;
  localparam int ACC_W = ENTRY_W + QUBITS;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_SCAN_RD, S_SCAN_MAG, S_SCAN_ACC, S_SQRT_GO, S_SQRT_WT,
    S_NRM_RD, S_NRM_LD, S_DIV_GO, S_DIV_WT, S_NRM_WR, S_COL, S_DONE
  } state_t;

  state_t              state;
  logic [AW-1:0]       idx;
  logic [AW-1:0]       hit;
  cmd_t                cur_cmd;
  logic [31:0]         thr;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    acc_next;
  logic [ENTRY_W-1:0]  mag;
  logic [ROOT_W-1:0]   root;
  amp_t                cur_re;
  amp_t                cur_im;
  amp_t                new_re;
  logic                part;
  logic [AW-1:0]       res_idx;
  status_t             res_st;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [ENTRY_W-1:0]  wdata;
  logic [ENTRY_W-1:0]  rdata;
  amp_t                rd_re;
  amp_t                rd_im;
  logic signed [ENTRY_W-1:0] p_re;
  logic signed [ENTRY_W-1:0] p_im;

  unit_ctl_t           uctl;
  logic                udone;
  logic [NUM_W-1:0]    ures;
  amp_t                div_part;
  logic [AMP_W-1:0]    div_abs;
  logic [NUM_W-1:0]    div_num;
  logic                last;
  logic                accept;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign last = &idx;
  assign rd_re = amp_t'(rdata[ENTRY_W-1:AMP_W]);
  assign rd_im = amp_t'(rdata[AMP_W-1:0]);
  assign p_re = rd_re * rd_re;
  assign p_im = rd_im * rd_im;
  assign acc_next = acc + ACC_W'(mag);
  assign div_part = part ? cur_im : cur_re;
  assign div_abs = div_part[AMP_W-1] ? AMP_W'(-div_part) : AMP_W'(div_part);
  assign div_num = (NUM_W'(div_abs) << 23) + NUM_W'(root);
  assign uctl.start = (state == S_SQRT_GO) || (state == S_DIV_GO);
  assign uctl.is_sqrt = (state == S_SQRT_GO);

  always_comb begin
    we = 1'b0;
    waddr = idx;
    wdata = '0;
    case (state)
      S_INIT: begin
        we = 1'b1;
        wdata = (idx == '0) ? {AMP_ONE, amp_t'(0)} : '0;
      end
      S_CLR: we = 1'b1;
      S_COL: begin
        we = 1'b1;
        wdata = (idx == hit) ? {AMP_ONE, amp_t'(0)} : '0;
      end
      S_NRM_WR: begin
        we = 1'b1;
        wdata = {new_re, sat_part(cur_im[AMP_W-1], ures)};
      end
      S_IDLE: begin
        we = accept && (cmd == CMD_WRITE);
        waddr = AW'(amp_index);
        wdata = {amp_real, amp_imag};
      end
      default: we = 1'b0;
    endcase
  end

  qsvs_store #(.AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(idx), .rdata(rdata)
  );

  qsvs_unit u_unit (
    .clk(clk), .rst(rst), .ctl(uctl), .sq_in(SQ_W'(acc) << 12), .num(div_num),
    .den({root, 1'b0}), .done(udone), .res(ures)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          idx <= idx + AW'(1);
          if (last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            cur_cmd <= cmd;
            thr <= {random_fraction, 16'h0000};
            idx <= '0;
            acc <= '0;
            res_idx <= '0;
            res_st <= ST_OK;
            case (cmd)
              CMD_CLEAR: state <= S_CLR;
              CMD_NORM, CMD_SAMPLE, CMD_COLLAPSE: state <= S_SCAN_RD;
              default: state <= S_DONE;
            endcase
          end
        end
        S_CLR, S_COL: begin
          idx <= idx + AW'(1);
          if (last) state <= S_DONE;
        end
        S_SCAN_RD: state <= S_SCAN_MAG;
        S_SCAN_MAG: begin
          mag <= ENTRY_W'(p_re) + ENTRY_W'(p_im);
          state <= S_SCAN_ACC;
        end
        S_SCAN_ACC: begin
          acc <= acc_next;
          if (cur_cmd != CMD_NORM && ACC_W'(thr) < acc_next) begin
            hit <= idx;
            res_idx <= idx;
            idx <= '0;
            state <= (cur_cmd == CMD_COLLAPSE) ? S_COL : S_DONE;
          end else if (last) begin
            idx <= '0;
            if (cur_cmd != CMD_NORM) begin
              res_st <= ST_NO_OUTCOME;
              state <= S_DONE;
            end else if (acc_next == '0) begin
              res_st <= ST_ZERO_NORM;
              state <= S_DONE;
            end else begin
              state <= S_SQRT_GO;
            end
          end else begin
            idx <= idx + AW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_SQRT_GO: state <= S_SQRT_WT;
        S_SQRT_WT: begin
          if (udone) begin
            root <= ures[ROOT_W-1:0];
            state <= S_NRM_RD;
          end
        end
        S_NRM_RD: state <= S_NRM_LD;
        S_NRM_LD: begin
          cur_re <= rd_re;
          cur_im <= rd_im;
          part <= 1'b0;
          state <= S_DIV_GO;
        end
        S_DIV_GO: state <= S_DIV_WT;
        S_DIV_WT: begin
          if (udone) begin
            if (!part) begin
              new_re <= sat_part(cur_re[AMP_W-1], ures);
              part <= 1'b1;
              state <= S_DIV_GO;
            end else begin
              state <= S_NRM_WR;
            end
          end
        end
        S_NRM_WR: begin
          idx <= idx + AW'(1);
          state <= last ? S_DONE : S_NRM_RD;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            outcome_index <= OUT_IDX_W'(res_idx);
            status <= res_st;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/qsvs_checker.sv]
// Port-level checks of the state vector sampler, bound to the top level.
// Depends on qsvs_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "quantum_state_vector_sampler_defines.svh"
module qsvs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [qsvs_pkg::OUT_IDX_W-1:0]   outcome_index,
  input qsvs_pkg::status_t                status
);
  import qsvs_pkg::*;

  `QSVS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(outcome_index) && $stable(status))
  `QSVS_ASSERT_NOW(a_status_code, out_valid, status == ST_OK || status == ST_ZERO_NORM || status == ST_NO_OUTCOME)
  `QSVS_ASSERT_NOW(a_fail_idx_zero, out_valid && status != ST_OK, outcome_index == '0)
  `QSVS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `QSVS_ASSERT_ALWAYS(a_reset_sweep, rst, !in_ready && !out_valid)
endmodule

bind quantum_state_vector_sampler qsvs_checker u_qsvs_checker (.*);

[verif/tb_quantum_state_vector_sampler.sv]
// Self-checking testbench for the state vector sampler: directed and random commands,
// predicted results compared field by field with every output transfer.
// Depends on qsvs_pkg and the quantum_state_vector_sampler RTL.
`timescale 1ns / 1ps
module tb_quantum_state_vector_sampler;
  import qsvs_pkg::*;

  localparam int DEPTH = 1024;

  typedef struct {
    cmd_t        op;
    logic [9:0]  idx;
    amp_t        re;
    amp_t        im;
    logic [15:0] draw;
  } command_t;

  typedef struct {
    logic [9:0] outcome;
    status_t    st;
  } measure_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cmd_t cmd = CMD_CLEAR;
  logic [9:0] amp_index = '0;
  amp_t amp_real = '0;
  amp_t amp_imag = '0;
  logic [15:0] random_fraction = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_IDX_W-1:0] outcome_index;
  status_t status;

  command_t pending[$];
  measure_t expected_measure[$];
  int state_re[DEPTH];
  int state_im[DEPTH];
  int errors = 0;
  bit calm = 1'b0;
  bit stim_done = 1'b0;

  quantum_state_vector_sampler dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .amp_index(amp_index), .amp_real(amp_real), .amp_imag(amp_imag),
    .random_fraction(random_fraction), .out_valid(out_valid), .out_ready(out_ready),
    .outcome_index(outcome_index), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void queue_cmd(command_t c);
    pending.insert(pending.size(), c);
  endfunction

  function automatic longint unsigned mag_sq(int k);
    longint a, b;
    a = state_re[k];
    b = state_im[k];
    return longint'(a * a) + longint'(b * b);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic int rescale(int a, longint unsigned r);
    longint unsigned m, q;
    longint v;
    m = (a < 0) ? -a : a;
    q = ((m << 23) + r) / (2 * r);
    v = (a < 0) ? -longint'(q) : longint'(q);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return int'(v);
  endfunction

  function automatic measure_t measure_step(command_t c);
    measure_t m;
    longint unsigned s, r, thr;
    bit found;
    int hit;
    m.outcome = '0;
    m.st = ST_OK;
    case (c.op)
      CMD_CLEAR: begin
        for (int k = 0; k < DEPTH; k++) begin
          state_re[k] = 0;
          state_im[k] = 0;
        end
      end
      CMD_WRITE: begin
        state_re[c.idx] = int'(c.re);
        state_im[c.idx] = int'(c.im);
      end
      CMD_NORM: begin
        s = 0;
        for (int k = 0; k < DEPTH; k++) s += mag_sq(k);
        if (s == 0) begin
          m.st = ST_ZERO_NORM;
        end else begin
          r = int_sqrt(s << 12);
          for (int k = 0; k < DEPTH; k++) begin
            state_re[k] = rescale(state_re[k], r);
            state_im[k] = rescale(state_im[k], r);
          end
        end
      end
      CMD_SAMPLE, CMD_COLLAPSE: begin
        thr = longint'(c.draw) << 16;
        s = 0;
        found = 1'b0;
        hit = 0;
        for (int k = 0; k < DEPTH && !found; k++) begin
          s += mag_sq(k);
          if (thr < s) begin
            found = 1'b1;
            hit = k;
          end
        end
        if (!found) begin
          m.st = ST_NO_OUTCOME;
        end else begin
          m.outcome = hit[9:0];
          if (c.op == CMD_COLLAPSE) begin
            for (int k = 0; k < DEPTH; k++) begin
              state_re[k] = (k == hit) ? 65536 : 0;
              state_im[k] = 0;
            end
          end
        end
      end
      default: ;
    endcase
    return m;
  endfunction

  function automatic command_t make_cmd(cmd_t op, int idx, int re, int im, int draw);
    command_t c;
    c.op = op;
    c.idx = idx[9:0];
    c.re = re[17:0];
    c.im = im[17:0];
    c.draw = draw[15:0];
    return c;
  endfunction

  bit taken = 1'b0;

  // Prediction on each accepted input, checking on each output transfer.
  always @(posedge clk) begin
    measure_t m;
    taken = 1'b0;
    if (!rst && in_valid && in_ready) begin
      taken = 1'b1;
      expected_measure.insert(expected_measure.size(),
                              measure_step(make_cmd(cmd, amp_index, amp_real, amp_imag,
                                                    random_fraction)));
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_measure.size() == 0) begin
        $error("unexpected result: outcome_index %0d status %0d", outcome_index, status);
        errors++;
      end else begin
        m = expected_measure.pop_front();
        if (outcome_index !== m.outcome) begin
          $error("outcome_index: expected %0d, actual %0d", m.outcome, outcome_index);
          errors++;
        end
        if (status !== m.st) begin
          $error("status: expected %0d, actual %0d", m.st, status);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    command_t c;
    if (!rst) begin
      out_ready <= calm || ($urandom_range(0, 99) >= 9);
      if (!in_valid || taken) begin
        if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
          c = pending.pop_front();
          in_valid <= 1'b1;
          cmd <= c.op;
          amp_index <= c.idx;
          amp_real <= c.re;
          amp_imag <= c.im;
          random_fraction <= c.draw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    int pick, norms;
    for (int k = 0; k < DEPTH; k++) begin
      state_re[k] = 0;
      state_im[k] = 0;
    end
    state_re[0] = 65536;

    queue_cmd(make_cmd(CMD_SAMPLE, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_SAMPLE, 0, 0, 0, 65535));
    queue_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_NORM, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_SAMPLE, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_COLLAPSE, 0, 0, 0, 12345));
    queue_cmd(make_cmd(CMD_WRITE, 1023, -131072, 131071, 0));
    queue_cmd(make_cmd(CMD_WRITE, 0, 131071, -131072, 65535));
    queue_cmd(make_cmd(CMD_WRITE, 512, 0, -1, 0));
    queue_cmd(make_cmd(5, 1023, -1, -1, 65535));
    queue_cmd(make_cmd(6, 0, 0, 0, 0));
    queue_cmd(make_cmd(7, 77, 5, 5, 5));
    queue_cmd(make_cmd(CMD_SAMPLE, 0, 0, 0, 65535));
    queue_cmd(make_cmd(CMD_NORM, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_SAMPLE, 0, 0, 0, 65535));
    queue_cmd(make_cmd(CMD_COLLAPSE, 0, 0, 0, 40000));
    queue_cmd(make_cmd(CMD_SAMPLE, 0, 0, 0, 65535));
    queue_cmd(make_cmd(CMD_WRITE, 3, 1, 0, 0));
    queue_cmd(make_cmd(CMD_SAMPLE, 0, 0, 0, 0));

    norms = 0;
    for (int n = 0; n < 270; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        queue_cmd(make_cmd(CMD_WRITE,
          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 31),
          $urandom_range(0, 262143) - 131072, $urandom_range(0, 262143) - 131072, $urandom));
      else if (pick < 60)
        queue_cmd(make_cmd(CMD_CLEAR, $urandom, 0, 0, $urandom));
      else if (pick < 63 && norms < 4) begin
        norms++;
        queue_cmd(make_cmd(CMD_NORM, $urandom, 0, 0, $urandom));
      end else if (pick < 80)
        queue_cmd(make_cmd(CMD_SAMPLE, $urandom, $urandom, 0, $urandom));
      else if (pick < 95)
        queue_cmd(make_cmd(CMD_COLLAPSE, $urandom, 0, $urandom, $urandom));
      else
        queue_cmd(make_cmd($urandom_range(5, 7), $urandom, $urandom, $urandom,
                           $urandom));
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    wait (pending.size() < 200);
    calm = 1'b1;
    wait (pending.size() < 140);
    calm = 1'b0;
    wait (pending.size() == 0 && !in_valid && expected_measure.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_measure.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
